/* sv/sparse_row_matrix_vector_product_top_macros.svh */
// assertion macros for the sparse row matrix vector product block
`ifndef SPARSE_ROW_MATRIX_VECTOR_PRODUCT_TOP_MACROS_SVH
`define SPARSE_ROW_MATRIX_VECTOR_PRODUCT_TOP_MACROS_SVH

// same-cycle implication
`define SRMV_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srmv check failed");

// next-cycle implication
`define SRMV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srmv check failed");

`endif

/* sv/srmv_pkg.sv */
// shared types and constants for the sparse row matrix vector product block
package srmv_pkg;

    localparam int IDX_W    = 12;
    localparam int FIELD_W  = 32;
    localparam int WIDE_W   = 128;

    localparam int VECTOR_DEPTH_DEF = 4096;
    localparam int DATA_WIDTH_DEF   = 32;
    localparam int ACC_WIDTH_DEF    = 64;
    localparam int FRAC_BITS_DEF    = 16;

    localparam int OFIFO_DEPTH = 8;
    localparam int CREDIT_W    = $clog2(OFIFO_DEPTH + 1);

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_ROW     = 2'd1;
    localparam logic [1:0] OP_OFFDIAG = 2'd2;

    typedef struct packed {
        logic               valid;
        logic [1:0]         op;
        logic               last;
        logic [IDX_W-1:0]   row;
        logic [FIELD_W-1:0] coef;
        logic [FIELD_W-1:0] rhs;
    } t_item;

    typedef struct packed {
        logic [IDX_W-1:0]   row;
        logic [FIELD_W-1:0] value;
        logic               sat;
    } t_res;

endpackage

/* sv/srmv_vstore.sv */
// vector store memory with index folding and registered read
module srmv_vstore #(
    parameter int DEPTH = srmv_pkg::VECTOR_DEPTH_DEF,
    parameter int WIDTH = srmv_pkg::DATA_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic                       i_we,
    input  logic [srmv_pkg::IDX_W-1:0] i_index,
    input  logic [WIDTH-1:0]           i_wdata,
    output logic [WIDTH-1:0]           o_rdata
);

    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam bit IS_POW2 = ((DEPTH & (DEPTH - 1)) == 0);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    addr;

    generate
        if (IS_POW2 && AW <= srmv_pkg::IDX_W) begin : g_mask
            assign addr = i_index[AW-1:0];
        end else begin : g_fold
            always_comb begin
                logic [srmv_pkg::IDX_W-1:0] rem;
                rem = i_index;
                for (int k = srmv_pkg::IDX_W - 1; k >= 0; k--) begin
                    if (((DEPTH << k) < (1 << srmv_pkg::IDX_W)) &&
                        (int'(rem) >= (DEPTH << k))) begin
                        rem = rem - srmv_pkg::IDX_W'(DEPTH << k);
                    end
                end
                addr = AW'(rem);
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[addr] <= i_wdata;
            end else begin
                o_rdata <= r_mem[addr];
            end
        end
    end

endmodule

/* sv/srmv_mac.sv */
// multiply, accumulate, residual and saturation stages
module srmv_mac #(
    parameter int DATA_WIDTH = srmv_pkg::DATA_WIDTH_DEF,
    parameter int ACC_WIDTH  = srmv_pkg::ACC_WIDTH_DEF,
    parameter int FRAC_BITS  = srmv_pkg::FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_mode,
    input  srmv_pkg::t_item       i_item,
    input  logic [DATA_WIDTH-1:0] i_vec,
    output logic                  o_valid,
    output srmv_pkg::t_res        o_res
);

    localparam int DW = DATA_WIDTH;
    localparam int AW = ACC_WIDTH;
    localparam int WW = srmv_pkg::WIDE_W;

    // multiply stage
    logic                         r2_valid;
    logic [1:0]                   r2_op;
    logic                         r2_last;
    logic [srmv_pkg::IDX_W-1:0]   r2_row;
    logic [DW-1:0]                r2_rhs;
    logic signed [2*DW-1:0]       r2_prod;

    // accumulate stage
    logic [AW-1:0]                r_acc;
    logic [AW-1:0]                n_acc;
    logic [srmv_pkg::IDX_W-1:0]   r_row;
    logic [DW-1:0]                r_rhs;
    logic                         r_emit;

    // residual stage
    logic                         r4_valid;
    logic [AW-1:0]                r4_v;
    logic [srmv_pkg::IDX_W-1:0]   r4_row;

    logic signed [2*DW-1:0]       prod_sh;
    logic signed [WW-1:0]         prod_wide;
    logic signed [WW-1:0]         rhs_wide;
    logic [AW-1:0]                inc;
    logic [AW-1:0]                rhs_acc;
    logic [DW-1:0]                sat_val;
    logic                         sat;
    logic signed [WW-1:0]         out_wide;

    always_ff @(posedge i_clk) begin
        r2_op   <= i_item.op;
        r2_last <= i_item.last;
        r2_row  <= i_item.row;
        r2_rhs  <= i_item.rhs[DW-1:0];
        r2_prod <= $signed(i_item.coef[DW-1:0]) * $signed(i_vec);
    end

    assign prod_sh   = r2_prod >>> FRAC_BITS;
    assign prod_wide = WW'(prod_sh);
    assign inc       = prod_wide[AW-1:0];

    always_comb begin
        n_acc = r_acc;
        if (r2_valid) begin
            case (r2_op)
                srmv_pkg::OP_ROW:     n_acc = inc;
                srmv_pkg::OP_OFFDIAG: n_acc = r_acc + inc;
                default:              n_acc = r_acc;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
            r_acc    <= '0;
            r_row    <= '0;
            r_rhs    <= '0;
            r_emit   <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            r2_valid <= i_item.valid;
            r_acc    <= n_acc;
            r_emit   <= r2_valid && r2_last;
            r4_valid <= r_emit;
            if (r2_valid && r2_op == srmv_pkg::OP_ROW) begin
                r_row <= r2_row;
                r_rhs <= r2_rhs;
            end
        end
    end

    assign rhs_wide = WW'($signed(r_rhs));
    assign rhs_acc  = rhs_wide[AW-1:0];

    always_ff @(posedge i_clk) begin
        r4_row <= r_row;
        r4_v   <= i_mode ? (rhs_acc - r_acc) : r_acc;
    end

    generate
        if (AW > DW) begin : g_clip
            logic [AW-DW:0] upper;
            logic           fits;
            assign upper   = r4_v[AW-1:DW-1];
            assign fits    = (&upper) || !(|upper);
            assign sat     = !fits;
            assign sat_val = fits ? r4_v[DW-1:0]
                           : (r4_v[AW-1] ? {1'b1, {(DW-1){1'b0}}}
                                         : {1'b0, {(DW-1){1'b1}}});
        end else begin : g_noclip
            logic signed [WW-1:0] acc_wide;
            assign acc_wide = WW'($signed(r4_v));
            assign sat      = 1'b0;
            assign sat_val  = acc_wide[DW-1:0];
        end
    endgenerate

    assign out_wide    = WW'($signed(sat_val));
    assign o_valid     = r4_valid;
    assign o_res.row   = r4_row;
    assign o_res.value = out_wide[srmv_pkg::FIELD_W-1:0];
    assign o_res.sat   = sat;

endmodule

/* sv/srmv_ofifo.sv */
// result queue between the pipeline and the output channel
module srmv_ofifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  srmv_pkg::t_res i_data,
    input  logic           i_pop,
    output logic           o_valid,
    output srmv_pkg::t_res o_data
);

    localparam int PW = $clog2(srmv_pkg::OFIFO_DEPTH);

    srmv_pkg::t_res                  r_buf [srmv_pkg::OFIFO_DEPTH];
    logic [PW-1:0]                   r_wp;
    logic [PW-1:0]                   r_rp;
    logic [srmv_pkg::CREDIT_W-1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            r_cnt <= r_cnt + srmv_pkg::CREDIT_W'(i_push) - srmv_pkg::CREDIT_W'(i_pop);
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_buf[r_rp];

endmodule

/* sv/sparse_row_matrix_vector_product_top.sv */
// top level of the sparse row matrix vector product block
//
// channel  dir  beat contents
// s_axis   in   tuser op, tdata index/coefficient/operand, tlast last
// m_axis   out  tdata row_index/result_value, tuser saturated
// cfg      in   i_cfg_we/i_cfg_wdata write mode, no read-back
//
// one beat per cycle while s_axis_tready is high; a result passes the store read, multiply,
// add and residual registers, then the clip logic, before it enters the result queue
// s_axis_tready falls only while eight results are queued or in flight
// reset is synchronous; the vector store is not cleared and needs no pass
`include "sparse_row_matrix_vector_product_top_macros.svh"

module sparse_row_matrix_vector_product_top #(
    parameter int VECTOR_DEPTH = srmv_pkg::VECTOR_DEPTH_DEF,
    parameter int DATA_WIDTH   = srmv_pkg::DATA_WIDTH_DEF,
    parameter int ACC_WIDTH    = srmv_pkg::ACC_WIDTH_DEF,
    parameter int FRAC_BITS    = srmv_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // index[11:0], coefficient[43:12], operand[75:44]
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // row_index[11:0], result_value[43:12]
    output logic [0:0]  m_axis_tuser    // saturated[0]
);

    logic                          r_mode;
    logic [srmv_pkg::CREDIT_W-1:0] r_credit;
    srmv_pkg::t_item               r_s1;
    logic                          accept;
    logic                          is_mac;
    logic                          produce;
    logic                          pop;
    logic [DATA_WIDTH-1:0]         vec;
    logic                          res_valid;
    srmv_pkg::t_res                res;
    srmv_pkg::t_res                head;

    assign accept  = s_axis_tvalid && s_axis_tready;
    assign is_mac  = (s_axis_tuser == srmv_pkg::OP_ROW) ||
                     (s_axis_tuser == srmv_pkg::OP_OFFDIAG);
    assign produce = accept && is_mac && s_axis_tlast;
    assign pop     = m_axis_tvalid && m_axis_tready;

    assign s_axis_tready = (r_credit < srmv_pkg::CREDIT_W'(srmv_pkg::OFIFO_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_credit <= '0;
            r_s1.valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            r_credit   <= r_credit + srmv_pkg::CREDIT_W'(produce)
                        - srmv_pkg::CREDIT_W'(pop);
            r_s1.valid <= accept && is_mac;
        end
        r_s1.op   <= s_axis_tuser;
        r_s1.last <= s_axis_tlast;
        r_s1.row  <= s_axis_tdata[11:0];
        r_s1.coef <= s_axis_tdata[43:12];
        r_s1.rhs  <= s_axis_tdata[75:44];
    end

    srmv_vstore #(
        .DEPTH (VECTOR_DEPTH),
        .WIDTH (DATA_WIDTH)
    ) u_vstore (
        .i_clk   (i_clk),
        .i_en    (accept && (is_mac || s_axis_tuser == srmv_pkg::OP_LOAD)),
        .i_we    (s_axis_tuser == srmv_pkg::OP_LOAD),
        .i_index (s_axis_tdata[11:0]),
        .i_wdata (s_axis_tdata[44 +: DATA_WIDTH]),
        .o_rdata (vec)
    );

    srmv_mac #(
        .DATA_WIDTH (DATA_WIDTH),
        .ACC_WIDTH  (ACC_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (r_mode),
        .i_item  (r_s1),
        .i_vec   (vec),
        .o_valid (res_valid),
        .o_res   (res)
    );

    srmv_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .i_pop   (pop),
        .o_valid (m_axis_tvalid),
        .o_data  (head)
    );

    assign m_axis_tdata = {4'b0000, head.value, head.row};
    assign m_axis_tuser = head.sat;

    `SRMV_ASSERT_NOW(a_credit_bound, i_clk, i_rst_n, 1'b1,
        r_credit <= srmv_pkg::CREDIT_W'(srmv_pkg::OFIFO_DEPTH))
    `SRMV_ASSERT_NOW(a_out_has_credit, i_clk, i_rst_n, m_axis_tvalid, r_credit != '0)
    `SRMV_ASSERT_NOW(a_full_blocks, i_clk, i_rst_n,
        r_credit == srmv_pkg::CREDIT_W'(srmv_pkg::OFIFO_DEPTH), !s_axis_tready)
    `SRMV_ASSERT_NEXT(a_pop_frees, i_clk, i_rst_n, pop && !produce,
        r_credit == $past(r_credit) - srmv_pkg::CREDIT_W'(1))

endmodule

/* test/tb.sv */
// testbench for the sparse row matrix vector product block: directed table, then random rows
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef srmv_pkg::t_res t_res;

    localparam logic [1:0] OP_LOAD    = srmv_pkg::OP_LOAD;
    localparam logic [1:0] OP_ROW     = srmv_pkg::OP_ROW;
    localparam logic [1:0] OP_OFFDIAG = srmv_pkg::OP_OFFDIAG;
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int FRAC = 16;
    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -Q_MAX - 1;
    localparam int PHASE_BEATS = 345;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT = 4000;

    typedef struct {
        bit          is_cfg;
        bit          mode;
        logic [1:0]  op;
        logic [11:0] idx;
        logic [31:0] coef;
        logic [31:0] opnd;
        logic        last;
        bit          typed;
        t_res        want;
    } t_plan_step;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;   // index[11:0], coefficient[43:12], operand[75:44]
    logic [1:0]  s_axis_tuser;   // op[1:0]
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // row_index[11:0], result_value[43:12]
    logic [0:0]  m_axis_tuser;   // saturated[0]

    // model state
    logic [31:0] vec_mem [0:4095];
    bit          vec_loaded [0:4095];
    int          filled_idx [$];
    longint      acc_sum;
    logic [11:0] cur_row;
    logic [31:0] rhs_q;
    bit          mode_q;

    t_res        pending_rows [$];
    t_plan_step  plan [$];
    int          fail_count;
    int          beats_sent;
    bit          tx_quiet;
    bit          rx_quiet;

    sparse_row_matrix_vector_product_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    function automatic longint scaled_prod(logic [31:0] a, logic [31:0] b);
        longint pa;
        longint pb;
        pa = longint'($signed(a));
        pb = longint'($signed(b));
        return (pa * pb) >>> FRAC;
    endfunction

    // advances the model by one accepted beat, returns 1 when a row result leaves
    function automatic bit row_step(logic [1:0] op, logic [11:0] idx, logic [31:0] coef,
                                    logic [31:0] opnd, logic last, output t_res res);
        longint v;
        bit     emits;
        emits = 1'b0;
        res = '0;
        case (op)
            OP_LOAD: begin
                vec_mem[idx] = opnd;
                if (!vec_loaded[idx]) begin
                    vec_loaded[idx] = 1'b1;
                    filled_idx.push_back(int'(idx));
                end
            end
            OP_ROW: begin
                cur_row = idx;
                rhs_q = opnd;
                acc_sum = scaled_prod(coef, vec_mem[idx]);
                emits = last;
            end
            OP_OFFDIAG: begin
                acc_sum = acc_sum + scaled_prod(coef, vec_mem[idx]);
                emits = last;
            end
            default: ;
        endcase
        if (emits) begin
            v = mode_q ? longint'($signed(rhs_q)) - acc_sum : acc_sum;
            res.row = cur_row;
            res.sat = (v > Q_MAX) || (v < Q_MIN);
            res.value = (v > Q_MAX) ? 32'h7fff_ffff : (v < Q_MIN) ? 32'h8000_0000 : v[31:0];
        end
        return emits;
    endfunction

    function automatic int gap_len(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // mostly small signed values so that results do not always clip
    function automatic logic [31:0] pick_q();
        case ($urandom_range(0, 9))
            0, 1: return $urandom;
            2: begin
                case ($urandom_range(0, 4))
                    0: return 32'h7fff_ffff;
                    1: return 32'h8000_0000;
                    2: return 32'hffff_ffff;
                    3: return 32'h0000_0001;
                    default: return 32'h0;
                endcase
            end
            default: return $urandom_range(0, 32'h1f_ffff) - 32'h10_0000;
        endcase
    endfunction

    function automatic logic [11:0] filled_col();
        return 12'(filled_idx[$urandom_range(0, filled_idx.size() - 1)]);
    endfunction

    task automatic send_beat(logic [1:0] op, logic [11:0] idx, logic [31:0] coef,
                             logic [31:0] opnd, logic last, bit typed = 1'b0,
                             t_res want = '0);
        int   gap;
        t_res res;
        @(negedge i_clk);
        if ($urandom_range(0, 79) == 0)
            tx_quiet = !tx_quiet;
        gap = gap_len(tx_quiet);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, opnd, coef, idx};
        s_axis_tuser <= op;
        s_axis_tlast <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        if (op != OP_SPARE)
            beats_sent++;
        if (row_step(op, idx, coef, opnd, last, res))
            pending_rows.push_back(typed ? want : res);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_mode(bit m);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        mode_q = m;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic plan_beat(logic [1:0] op, logic [11:0] idx, logic [31:0] coef,
                             logic [31:0] opnd, logic last, bit typed = 1'b0,
                             logic [11:0] wrow = '0, logic [31:0] wval = '0,
                             logic wsat = 1'b0);
        t_plan_step s;
        s = '{default: '0};
        s.op = op;
        s.idx = idx;
        s.coef = coef;
        s.opnd = opnd;
        s.last = last;
        s.typed = typed;
        s.want.row = wrow;
        s.want.value = wval;
        s.want.sat = wsat;
        plan.push_back(s);
    endtask

    task automatic plan_mode(bit m);
        t_plan_step s;
        s = '{default: '0};
        s.is_cfg = 1'b1;
        s.mode = m;
        plan.push_back(s);
    endtask

    // result side
    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.row = m_axis_tdata[11:0];
            got.value = m_axis_tdata[43:12];
            got.sat = m_axis_tuser[0];
            if (pending_rows.size() == 0) begin
                $error("result beat for row %0d with no pending row", got.row);
                fail_count++;
            end else begin
                want = pending_rows.pop_front();
                if (got.row !== want.row) begin
                    $error("row_index: expected %0d, got %0d", want.row, got.row);
                    fail_count++;
                end
                if (got.value !== want.value) begin
                    $error("result_value: expected %h, got %h", want.value, got.value);
                    fail_count++;
                end
                if (got.sat !== want.sat) begin
                    $error("saturated: expected %0d, got %0d", want.sat, got.sat);
                    fail_count++;
                end
            end
        end
    end

    // receiver stalls
    initial begin
        int stall;
        stall = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 79) == 0)
                rx_quiet = !rx_quiet;
            if (stall == 0 && $urandom_range(0, 3) == 0)
                stall = gap_len(rx_quiet);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                stall--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        int pick;
        int k;
        int phase_end;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        s_axis_tlast = 1'b0;
        acc_sum = 0;
        cur_row = '0;
        rhs_q = '0;
        mode_q = 1'b0;
        fail_count = 0;
        beats_sent = 0;
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        plan_beat(OP_LOAD, 0, 32'h0, 32'h0001_0000, 1'b0);
        plan_beat(OP_LOAD, 4095, 32'hffff_ffff, 32'h7fff_ffff, 1'b1);
        plan_beat(OP_LOAD, 1, 32'h0, 32'h8000_0000, 1'b0);
        plan_beat(OP_LOAD, 2, 32'h0, 32'h0002_0000, 1'b0);
        plan_beat(OP_LOAD, 3, 32'h0, 32'h0000_0001, 1'b0);
        plan_beat(OP_SPARE, 4095, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
        plan_beat(OP_ROW, 0, 32'h0003_0000, 32'h0, 1'b1, 1'b1, 0, 32'h0003_0000, 1'b0);
        plan_beat(OP_ROW, 4095, 32'h7fff_ffff, 32'h0, 1'b0);
        plan_beat(OP_OFFDIAG, 4095, 32'h7fff_ffff, 32'h0, 1'b1,
                  1'b1, 4095, 32'h7fff_ffff, 1'b1);
        plan_beat(OP_ROW, 1, 32'h7fff_ffff, 32'h0, 1'b1, 1'b1, 1, 32'h8000_0000, 1'b1);
        // off-diagonal with no row start
        plan_beat(OP_OFFDIAG, 2, 32'h0001_0000, 32'h0, 1'b1);
        // floor rounding of a tiny negative product
        plan_beat(OP_ROW, 3, 32'hffff_ffff, 32'h0, 1'b1, 1'b1, 3, 32'hffff_ffff, 1'b0);
        plan_beat(OP_ROW, 2, 32'h0000_0001, 32'h0, 1'b1, 1'b1, 2, 32'h0000_0002, 1'b0);
        plan_mode(1'b1);
        plan_beat(OP_ROW, 0, 32'h0001_0000, 32'h0005_0000, 1'b0);
        plan_beat(OP_OFFDIAG, 2, 32'h0001_0000, 32'h0, 1'b1, 1'b1, 0, 32'h0002_0000, 1'b0);
        plan_beat(OP_ROW, 4095, 32'h7fff_ffff, 32'h8000_0000, 1'b1,
                  1'b1, 4095, 32'h8000_0000, 1'b1);
        plan_beat(OP_ROW, 0, 32'h0, 32'h7fff_ffff, 1'b1, 1'b1, 0, 32'h7fff_ffff, 1'b0);
        plan_beat(OP_OFFDIAG, 1, 32'h8000_0000, 32'h0, 1'b1);
        plan_mode(1'b0);

        foreach (plan[i]) begin
            if (plan[i].is_cfg)
                set_mode(plan[i].mode);
            else
                send_beat(plan[i].op, plan[i].idx, plan[i].coef, plan[i].opnd, plan[i].last,
                          plan[i].typed, plan[i].want);
        end

        for (int ph = 0; ph < 4; ph++) begin
            set_mode(ph % 2 == 0);
            if (ph == 0)
                repeat (32) send_beat(OP_LOAD, 12'($urandom_range(0, 4095)), $urandom,
                                      pick_q(), 1'b0);
            phase_end = beats_sent + PHASE_BEATS;
            while (beats_sent < phase_end) begin
                pick = $urandom_range(0, 99);
                if (pick < 12) begin
                    repeat ($urandom_range(1, 4))
                        send_beat(OP_LOAD, ($urandom_range(0, 3) == 0) ? filled_col() :
                                  12'($urandom_range(0, 4095)), $urandom, pick_q(),
                                  1'($urandom_range(0, 7) == 0));
                end else if (pick < 88) begin
                    k = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 16)
                                                    : $urandom_range(0, 5);
                    send_beat(OP_ROW, filled_col(), pick_q(), pick_q(), k == 0);
                    for (int j = 0; j < k; j++) begin
                        // a load in the middle of a row, to an entry already filled
                        if ($urandom_range(0, 9) == 0)
                            send_beat(OP_LOAD, filled_col(), $urandom, pick_q(), 1'b0);
                        send_beat(OP_OFFDIAG, filled_col(), pick_q(), $urandom, j == k - 1);
                    end
                end else begin
                    case ($urandom_range(0, 2))
                        0: send_beat(OP_SPARE, 12'($urandom), $urandom, $urandom, 1'($urandom));
                        1: send_beat(OP_OFFDIAG, filled_col(), pick_q(), $urandom, 1'($urandom));
                        default: send_beat(OP_ROW, filled_col(), pick_q(), pick_q(), 1'b0);
                    endcase
                end
            end
        end

        wait_drained();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+sv
sv/srmv_pkg.sv
sv/srmv_vstore.sv
sv/srmv_mac.sv
sv/srmv_ofifo.sv
sv/sparse_row_matrix_vector_product_top.sv
test/tb.sv
